/* hdl/nwl_pkg.sv */
// ----------------------------------------------------------------------------
// nwl_pkg
// Shared widths, register indexes, codes and control structs of the nearest
// waypoint lookup block.
// ----------------------------------------------------------------------------
package nwl_pkg;

  localparam int MAX_WAYPOINTS = 64;
  localparam int SLOT_W        = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W         = 7;
  localparam int ID_W          = 8;
  localparam int COORD_W       = 16;
  localparam int DIFF_W        = COORD_W;
  localparam int SQ_W          = 2 * DIFF_W;
  localparam int DIST_W        = 33;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = DIST_W;
  localparam int ENTRY_W       = ID_W + 2 * COORD_W;

  localparam logic [DIST_W-1:0] THRESHOLD_RESET = 33'd8589672450;
  localparam logic [CNT_W-1:0]  CNT_MAX         = CNT_W'(MAX_WAYPOINTS);

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SQ = 1'd1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic              start;     // latch query position, clear best
    logic              wr;        // write the input beat into the table
    logic              rd;        // read one table entry into the scan pipe
    logic [SLOT_W-1:0] rd_addr;
    logic              out_load;  // capture the final result
  } nwl_cmd_t;

  typedef struct packed {
    logic busy;                   // scan pipeline still holds entries
  } nwl_sts_t;

endpackage

/* hdl/nearest_waypoint_lookup_core.sv */
// ----------------------------------------------------------------------------
// nearest_waypoint_lookup_core
// Nearest waypoint search over a 64-entry table with a squared distance
// threshold; loads write the table, queries return one result beat.
// ----------------------------------------------------------------------------
//  Channel  Ports                                    Direction  Beat
//  in       in_valid/in_ready + action,slot,id,x,y   input      load or query
//  out      out_valid/out_ready + found,id,dist      output     one per query
//  cfg      cfg_we, cfg_index, cfg_wdata             input      register write
//
// A load is written into the table when accepted. A query scans N entries,
// N being active_count capped at 64, and goes straight to the result when N
// is 0: the table memory gives one entry per cycle to the distance pipeline.
// Input is held off during a query. A result waiting on out_ready blocks only
// the end of the next query; loads keep flowing. Reset clears control state
// and the registers; the table holds nothing defined until written.
// ----------------------------------------------------------------------------
module nearest_waypoint_lookup_core
  import nwl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [SLOT_W-1:0]         in_slot,
  input  logic [ID_W-1:0]           in_waypoint_id,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [ID_W-1:0]           out_nearest_id,
  output logic [DIST_W-1:0]         out_distance_sq,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

  logic [CNT_W-1:0]  active_count_r;
  logic [DIST_W-1:0] threshold_sq_r;
  nwl_cmd_t          cmd;
  nwl_sts_t          sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= '0;
      threshold_sq_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_COUNT: active_count_r <= cfg_wdata[CNT_W-1:0];
        REG_THRESHOLD_SQ: threshold_sq_r <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  nwl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .active_count (active_count_r),
    .cmd          (cmd),
    .sts          (sts)
  );

  nwl_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_slot         (in_slot),
    .in_waypoint_id  (in_waypoint_id),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .threshold_sq    (threshold_sq_r),
    .out_found       (out_found),
    .out_nearest_id  (out_nearest_id),
    .out_distance_sq (out_distance_sq)
  );

endmodule

/* hdl/nwl_ctrl.sv */
// ----------------------------------------------------------------------------
// nwl_ctrl
// Sequencer: takes input beats, steps the table scan of a query and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module nwl_ctrl
  import nwl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic [CNT_W-1:0] active_count,
  output nwl_cmd_t         cmd,
  input  nwl_sts_t         sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] num_r, num_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] num_sat;
  logic [CNT_W-1:0] cnt_inc;
  logic             in_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign num_sat   = (active_count > CNT_MAX) ? CNT_MAX : active_count;
  assign cnt_inc   = cnt_r + CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    num_nxt       = num_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.rd_addr   = cnt_r[SLOT_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_QUERY) begin
            cmd.start = 1'b1;
            cnt_nxt   = '0;
            num_nxt   = num_sat;
            state_nxt = (num_sat == '0) ? ST_FIN : ST_SCAN;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd  = 1'b1;
        cnt_nxt = cnt_inc;
        if (cnt_inc == num_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // The result register must be free before a new result goes in.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      num_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      num_r       <= num_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/nwl_dp.sv */
// ----------------------------------------------------------------------------
// nwl_dp
// Datapath: waypoint table memory, distance pipeline, running minimum and
// the result register.
// ----------------------------------------------------------------------------
module nwl_dp
  import nwl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  nwl_cmd_t                  cmd,
  output nwl_sts_t                  sts,
  input  logic [SLOT_W-1:0]         in_slot,
  input  logic [ID_W-1:0]           in_waypoint_id,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic [DIST_W-1:0]         threshold_sq,
  output logic                      out_found,
  output logic [ID_W-1:0]           out_nearest_id,
  output logic [DIST_W-1:0]         out_distance_sq
);

  logic [ENTRY_W-1:0] table_mem [MAX_WAYPOINTS];

  logic signed [COORD_W-1:0] qx_r, qy_r;

  // Stage 1: registered memory read.
  logic                      v1_r;
  logic [ENTRY_W-1:0]        rd_data_r;
  // Stage 2: absolute coordinate differences.
  logic                      v2_r;
  logic [ID_W-1:0]           id2_r;
  logic [DIFF_W-1:0]         adx_r, ady_r;
  // Stage 3: squares.
  logic                      v3_r;
  logic [ID_W-1:0]           id3_r;
  logic [SQ_W-1:0]           sqx_r, sqy_r;
  // Running minimum.
  logic                      any_r;
  logic [DIST_W-1:0]         best_r;
  logic [ID_W-1:0]           best_id_r;

  logic [ID_W-1:0]           e_id;
  logic signed [COORD_W-1:0] e_x, e_y;
  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W:0]          dx_abs, dy_abs;
  logic [DIST_W-1:0]         sum;
  logic                      take;
  logic                      found;

  assign sts.busy = v1_r || v2_r || v3_r;

  assign e_id = rd_data_r[ENTRY_W-1 -: ID_W];
  assign e_x  = rd_data_r[2*COORD_W-1 -: COORD_W];
  assign e_y  = rd_data_r[COORD_W-1:0];

  assign dx     = {e_x[COORD_W-1], e_x} - {qx_r[COORD_W-1], qx_r};
  assign dy     = {e_y[COORD_W-1], e_y} - {qy_r[COORD_W-1], qy_r};
  assign dx_abs = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
  assign dy_abs = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);

  assign sum   = DIST_W'(sqx_r) + DIST_W'(sqy_r);
  // Strict less-than keeps the earliest slot on a tie.
  assign take  = v3_r && (!any_r || (sum < best_r));
  assign found = any_r && (best_r <= threshold_sq);

  always_ff @(posedge clk) begin
    if (cmd.wr && ({1'b0, in_slot} < (SLOT_W+1)'(MAX_WAYPOINTS))) begin
      table_mem[in_slot] <= {in_waypoint_id, in_pos_x, in_pos_y};
    end
    if (cmd.rd) begin
      rd_data_r <= table_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      any_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.start) begin
        any_r <= 1'b0;
      end else if (take) begin
        any_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx_r <= in_pos_x;
      qy_r <= in_pos_y;
    end
    id2_r <= e_id;
    adx_r <= dx_abs[DIFF_W-1:0];
    ady_r <= dy_abs[DIFF_W-1:0];
    id3_r <= id2_r;
    sqx_r <= SQ_W'(adx_r) * SQ_W'(adx_r);
    sqy_r <= SQ_W'(ady_r) * SQ_W'(ady_r);
    if (take) begin
      best_r    <= sum;
      best_id_r <= id3_r;
    end
    if (cmd.out_load) begin
      out_found       <= found;
      out_nearest_id  <= found ? best_id_r : '0;
      out_distance_sq <= any_r ? best_r : '0;
    end
  end

endmodule
